>>> rtl/core/sgs_pkg.sv
// shared types, constants and helpers of the grid step core
`timescale 1ns / 1ps

package sgs_pkg;

    localparam int GRID_ROWS = 64;
    localparam int GRID_COLS = 64;
    localparam int CELLS     = GRID_ROWS * GRID_COLS;
    localparam int CELL_W    = $clog2(CELLS);
    localparam int ROW_W     = $clog2(GRID_ROWS);
    localparam int COL_W     = $clog2(GRID_COLS);
    localparam int WORD_W    = 32;
    localparam int FRAC_W    = 24;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [CELL_W-1:0] cell_addr_t;
    typedef logic signed [2*WORD_W-1:0] prod_t;

    typedef enum logic [1:0] {
        ACT_WRITE = 2'd0,
        ACT_READ  = 2'd1,
        ACT_STEP  = 2'd2
    } action_t;

    typedef enum logic [1:0] {
        CFG_LAP_SCALE_RE = 2'd0,
        CFG_LAP_SCALE_IM = 2'd1,
        CFG_KINETIC      = 2'd2,
        CFG_TIME         = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        TAP_EAST   = 3'd0,
        TAP_WEST   = 3'd1,
        TAP_SOUTH  = 3'd2,
        TAP_NORTH  = 3'd3,
        TAP_CENTER = 3'd4
    } tap_t;

    typedef enum logic [1:0] {
        RES_ZERO = 2'd0,
        RES_CELL = 2'd1,
        RES_STEP = 2'd2
    } res_kind_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [5:0]         row;
        logic [5:0]         col;
        logic signed [31:0] value_real;
        logic signed [31:0] value_imag;
        logic signed [31:0] potential_in;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] cell_real;
        logic signed [31:0] cell_imag;
        logic signed [31:0] cell_potential;
        logic               step_done;
    } out_item_t;

    typedef struct packed {
        cell_addr_t rd_addr;
        cell_addr_t wr_addr;
        logic       wr_input;
        logic       wr_lap;
        logic       wr_upd;
        logic       tap_vld;
        tap_t       tap;
        logic       lap_mul;
        logic       upd_mul1;
        logic       upd_mul2;
        logic       res_load;
        res_kind_t  res_kind;
    } sgs_cmd_t;

    localparam word_t LAP_SCALE_RST = 32'h0080_0000;
    localparam word_t KINETIC_RST   = 32'hFF80_0000;
    localparam word_t TIME_RST      = 32'h0002_8F5C;

    function automatic cell_addr_t cell_addr(input logic [5:0] r, input logic [5:0] c);
        cell_addr = CELL_W'(r) * CELL_W'(GRID_COLS) + CELL_W'(c);
    endfunction

    // q8.24 product bits after the floor shift, wrapped to one word
    function automatic word_t q_hi(input prod_t p);
        q_hi = p[FRAC_W+WORD_W-1:FRAC_W];
    endfunction

endpackage

>>> rtl/core/sgs_ram.sv
// generic single write, single registered read port ram
`timescale 1ns / 1ps

module sgs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/sgs_dpath.sv
// grid memories, stencil accumulator, multipliers and result register
`timescale 1ns / 1ps

module sgs_dpath import sgs_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  sgs_cmd_t  cmd,
    input  in_item_t  in_data,
    input  logic      cfg_we,
    input  logic [1:0] cfg_index,
    input  word_t     cfg_data,
    output out_item_t out_data
);

    word_t scale_re_reg, scale_im_reg, kin_reg, time_reg;
    word_t scale_re_next, scale_im_next, kin_next, time_next;

    word_t rd_re, rd_im, rd_pot, rd_lre, rd_lim;
    word_t wre_data, wim_data;
    logic  wave_we;

    logic tap_vld_d_reg;
    tap_t tap_d_reg;

    word_t acc_re_reg, acc_im_reg, acc_re_next, acc_im_next;
    prod_t lap_p_re_reg, lap_p_im_reg;
    prod_t p_vre_reg, p_klr_reg, p_vim_reg, p_kli_reg;
    word_t re_old_reg, im_old_reg;
    word_t t_re, t_im;
    prod_t q_re_reg, q_im_reg;
    out_item_t res_reg, res_next;

    // configuration registers
    always_comb
    begin
        scale_re_next = scale_re_reg;
        scale_im_next = scale_im_reg;
        kin_next      = kin_reg;
        time_next     = time_reg;
        if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_LAP_SCALE_RE: scale_re_next = cfg_data;
                CFG_LAP_SCALE_IM: scale_im_next = cfg_data;
                CFG_KINETIC:      kin_next      = cfg_data;
                CFG_TIME:         time_next     = cfg_data;
                default:          ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scale_re_reg  <= LAP_SCALE_RST;
            scale_im_reg  <= LAP_SCALE_RST;
            kin_reg       <= KINETIC_RST;
            time_reg      <= TIME_RST;
            tap_vld_d_reg <= 1'b0;
            tap_d_reg     <= TAP_EAST;
        end
        else
        begin
            scale_re_reg  <= scale_re_next;
            scale_im_reg  <= scale_im_next;
            kin_reg       <= kin_next;
            time_reg      <= time_next;
            tap_vld_d_reg <= cmd.tap_vld;
            tap_d_reg     <= cmd.tap;
        end
    end

    // wave write data: host write or update pass
    assign wave_we  = cmd.wr_input | cmd.wr_upd;
    assign wre_data = cmd.wr_input ? word_t'(in_data.value_real) : re_old_reg + q_hi(q_re_reg);
    assign wim_data = cmd.wr_input ? word_t'(in_data.value_imag) : im_old_reg - q_hi(q_im_reg);

    sgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_wave_re (
        .clk(clk), .wr_en(wave_we), .wr_addr(cmd.wr_addr), .wr_data(wre_data),
        .rd_addr(cmd.rd_addr), .rd_data(rd_re)
    );
    sgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_wave_im (
        .clk(clk), .wr_en(wave_we), .wr_addr(cmd.wr_addr), .wr_data(wim_data),
        .rd_addr(cmd.rd_addr), .rd_data(rd_im)
    );
    sgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_pot (
        .clk(clk), .wr_en(cmd.wr_input), .wr_addr(cmd.wr_addr),
        .wr_data(word_t'(in_data.potential_in)),
        .rd_addr(cmd.rd_addr), .rd_data(rd_pot)
    );
    sgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_lap_re (
        .clk(clk), .wr_en(cmd.wr_lap), .wr_addr(cmd.wr_addr), .wr_data(q_hi(lap_p_re_reg)),
        .rd_addr(cmd.rd_addr), .rd_data(rd_lre)
    );
    sgs_ram #(.WIDTH(WORD_W), .DEPTH(CELLS)) u_lap_im (
        .clk(clk), .wr_en(cmd.wr_lap), .wr_addr(cmd.wr_addr), .wr_data(q_hi(lap_p_im_reg)),
        .rd_addr(cmd.rd_addr), .rd_data(rd_lim)
    );

    // five point stencil, one tap per cycle
    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (tap_vld_d_reg)
        begin
            case (tap_d_reg) inside
                TAP_EAST:
                begin
                    acc_re_next = rd_re;
                    acc_im_next = rd_im;
                end
                TAP_WEST, TAP_SOUTH, TAP_NORTH:
                begin
                    acc_re_next = acc_re_reg + rd_re;
                    acc_im_next = acc_im_reg + rd_im;
                end
                TAP_CENTER:
                begin
                    acc_re_next = acc_re_reg - {rd_re[WORD_W-3:0], 2'b00};
                    acc_im_next = acc_im_reg - {rd_im[WORD_W-3:0], 2'b00};
                end
                default: ;
            endcase
        end
    end

    assign t_re = q_hi(p_vre_reg) + q_hi(p_klr_reg);
    assign t_im = q_hi(p_vim_reg) + q_hi(p_kli_reg);

    always_comb
    begin
        res_next = res_reg;
        if (cmd.res_load)
        begin
            res_next = '0;
            case (cmd.res_kind)
                RES_CELL:
                begin
                    res_next.cell_real      = rd_re;
                    res_next.cell_imag      = rd_im;
                    res_next.cell_potential = rd_pot;
                end
                RES_STEP: res_next.step_done = 1'b1;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        acc_re_reg <= acc_re_next;
        acc_im_reg <= acc_im_next;
        res_reg    <= res_next;
        if (cmd.lap_mul)
        begin
            lap_p_re_reg <= $signed(scale_re_reg) * $signed(acc_re_reg);
            lap_p_im_reg <= $signed(scale_im_reg) * $signed(acc_im_reg);
        end
        if (cmd.upd_mul1)
        begin
            p_vre_reg  <= $signed(rd_pot) * $signed(rd_re);
            p_klr_reg  <= $signed(kin_reg) * $signed(rd_lre);
            p_vim_reg  <= $signed(rd_pot) * $signed(rd_im);
            p_kli_reg  <= $signed(kin_reg) * $signed(rd_lim);
            re_old_reg <= rd_re;
            im_old_reg <= rd_im;
        end
        if (cmd.upd_mul2)
        begin
            q_re_reg <= $signed(time_reg) * $signed(t_im);
            q_im_reg <= $signed(time_reg) * $signed(t_re);
        end
    end

    assign out_data = res_reg;

endmodule

>>> rtl/core/sgs_ctrl.sv
// sequencer: request decode, grid walk counters and output valid
`timescale 1ns / 1ps

module sgs_ctrl import sgs_pkg::*; (
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  in_item_t in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output sgs_cmd_t cmd
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b000_0000_0001,
        S_READ     = 11'b000_0000_0010,
        S_LAP_RD   = 11'b000_0000_0100,
        S_LAP_ACC  = 11'b000_0000_1000,
        S_LAP_MUL  = 11'b000_0001_0000,
        S_LAP_WR   = 11'b000_0010_0000,
        S_UPD_RD   = 11'b000_0100_0000,
        S_UPD_MUL1 = 11'b000_1000_0000,
        S_UPD_MUL2 = 11'b001_0000_0000,
        S_UPD_WR   = 11'b010_0000_0000,
        S_SPARE    = 11'b100_0000_0000
    } state_t;

    localparam cell_addr_t START_CELL = CELL_W'(GRID_COLS + 1);

    state_t     state_reg, state_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    cell_addr_t center_reg, center_next;
    tap_t       tap_reg, tap_next;
    logic       rd_inside_reg, rd_inside_next;
    logic       out_valid_reg, out_valid_next;

    logic       accept, in_inside, last_cell, row_end;
    cell_addr_t in_addr, tap_addr;

    assign in_ready  = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign in_addr   = cell_addr(in_data.row, in_data.col);
    assign in_inside = (int'(in_data.row) < GRID_ROWS) && (int'(in_data.col) < GRID_COLS);
    assign row_end   = (col_reg == COL_W'(GRID_COLS - 2));
    assign last_cell = row_end && (row_reg == ROW_W'(GRID_ROWS - 2));

    always_comb
    begin
        unique case (tap_reg)
            TAP_EAST:  tap_addr = center_reg + CELL_W'(1);
            TAP_WEST:  tap_addr = center_reg - CELL_W'(1);
            TAP_SOUTH: tap_addr = center_reg + CELL_W'(GRID_COLS);
            TAP_NORTH: tap_addr = center_reg - CELL_W'(GRID_COLS);
            default:   tap_addr = center_reg;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        center_next    = center_reg;
        tap_next       = tap_reg;
        rd_inside_next = rd_inside_reg;
        cmd            = '0;
        cmd.rd_addr    = center_reg;
        cmd.wr_addr    = center_reg;
        cmd.tap        = tap_reg;
        cmd.res_kind   = RES_ZERO;

        unique case (state_reg)
            S_IDLE:
            begin
                cmd.rd_addr = in_addr;
                cmd.wr_addr = in_addr;
                if (accept)
                begin
                    case (in_data.action)
                        ACT_WRITE:
                        begin
                            cmd.wr_input = in_inside;
                            cmd.res_load = 1'b1;
                        end
                        ACT_READ:
                        begin
                            rd_inside_next = in_inside;
                            state_next     = S_READ;
                        end
                        ACT_STEP:
                        begin
                            row_next    = ROW_W'(1);
                            col_next    = COL_W'(1);
                            center_next = START_CELL;
                            tap_next    = TAP_EAST;
                            state_next  = S_LAP_RD;
                        end
                        default: cmd.res_load = 1'b1;
                    endcase
                end
            end
            S_READ:
            begin
                cmd.res_load = 1'b1;
                cmd.res_kind = rd_inside_reg ? RES_CELL : RES_ZERO;
                state_next   = S_IDLE;
            end
            S_LAP_RD:
            begin
                cmd.rd_addr = tap_addr;
                cmd.tap_vld = 1'b1;
                unique case (tap_reg)
                    TAP_EAST:  tap_next = TAP_WEST;
                    TAP_WEST:  tap_next = TAP_SOUTH;
                    TAP_SOUTH: tap_next = TAP_NORTH;
                    TAP_NORTH: tap_next = TAP_CENTER;
                    default:   state_next = S_LAP_ACC;
                endcase
            end
            S_LAP_ACC: state_next = S_LAP_MUL;
            S_LAP_MUL:
            begin
                cmd.lap_mul = 1'b1;
                state_next  = S_LAP_WR;
            end
            S_LAP_WR:
            begin
                cmd.wr_lap = 1'b1;
                tap_next   = TAP_EAST;
                if (last_cell)
                begin
                    row_next    = ROW_W'(1);
                    col_next    = COL_W'(1);
                    center_next = START_CELL;
                    state_next  = S_UPD_RD;
                end
                else
                begin
                    state_next = S_LAP_RD;
                    if (row_end)
                    begin
                        row_next    = row_reg + ROW_W'(1);
                        col_next    = COL_W'(1);
                        center_next = center_reg + CELL_W'(3);
                    end
                    else
                    begin
                        col_next    = col_reg + COL_W'(1);
                        center_next = center_reg + CELL_W'(1);
                    end
                end
            end
            S_UPD_RD: state_next = S_UPD_MUL1;
            S_UPD_MUL1:
            begin
                cmd.upd_mul1 = 1'b1;
                state_next   = S_UPD_MUL2;
            end
            S_UPD_MUL2:
            begin
                cmd.upd_mul2 = 1'b1;
                state_next   = S_UPD_WR;
            end
            S_UPD_WR:
            begin
                cmd.wr_upd = 1'b1;
                if (last_cell)
                begin
                    cmd.res_load = 1'b1;
                    cmd.res_kind = RES_STEP;
                    state_next   = S_IDLE;
                end
                else
                begin
                    state_next = S_UPD_RD;
                    if (row_end)
                    begin
                        row_next    = row_reg + ROW_W'(1);
                        col_next    = COL_W'(1);
                        center_next = center_reg + CELL_W'(3);
                    end
                    else
                    begin
                        col_next    = col_reg + COL_W'(1);
                        center_next = center_reg + CELL_W'(1);
                    end
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign out_valid_next = cmd.res_load ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    assign out_valid      = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            center_reg    <= '0;
            tap_reg       <= TAP_EAST;
            rd_inside_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            center_reg    <= center_next;
            tap_reg       <= tap_next;
            rd_inside_reg <= rd_inside_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

>>> rtl/core/schrodinger_grid_step_core.sv
// top level of the explicit euler wave grid step core
`timescale 1ns / 1ps
// usage:
// - input channel in_valid/in_ready/in_data carries one request: write a cell,
//   read a cell or run one time step over the whole grid
// - output channel out_valid/out_ready/out_data returns exactly one result per
//   request; reads return the cell, a step returns step_done, others all zero
// - config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the four
//   q8.24 coefficients; cfg_ready is always high, write only while idle
// - write and unused requests answer in the cycle after acceptance; a read goes via S_READ
// - a step walks the interior twice: the laplacian pass reads five taps through the one
//   wave read port, then accumulates, scale multiplies and writes; the update pass reads,
//   does four multiplies, then two time coefficient multiplies, and writes back
// - one request is in work at a time; a new one is taken while a finished
//   result still sits in the output register if that result leaves the same
//   cycle
// - a stalled receiver holds the result register and blocks new requests
// - reset clears the sequencer and restores coefficient defaults; grid
//   memories are not cleared and read as undefined until written
module schrodinger_grid_step_core import sgs_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  in_item_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output out_item_t  out_data,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  word_t      cfg_data
);

    sgs_cmd_t cmd;

    // configuration is always taken; cfg_ready is tied high
    assign cfg_ready = 1'b1;

    sgs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    sgs_dpath u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (out_data)
    );

    // a step result never carries cell data
    a_step_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.step_done |->
            out_data.cell_real == 0 && out_data.cell_imag == 0 &&
            out_data.cell_potential == 0)
        else $error("step result with cell data");

    // a write request is answered at the next edge
    a_write_lat: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_WRITE |=>
            out_valid && !out_data.step_done)
        else $error("write request not answered");

    // a step keeps the input closed while the grid is walked
    a_step_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.action == ACT_STEP |=> !in_ready && !out_valid)
        else $error("input open during step");

endmodule

>>> tb/tb.sv
// self-checking testbench of the wave grid step core
`timescale 1ns / 1ps

module tb;
    import sgs_pkg::*;

    localparam int CYCLE_LIMIT = 3_000_000;

    // tracks the grid contents and coefficients and holds the results still owed
    class grid_scoreboard;
        word_t wave_re[CELLS];
        word_t wave_im[CELLS];
        word_t pot[CELLS];
        word_t lap_re[CELLS];
        word_t lap_im[CELLS];
        word_t coeff[4];
        out_item_t owed[$];
        int errors;
        int n_write;
        int n_read;
        int n_step;
        int n_other;

        function new();
            coeff[CFG_LAP_SCALE_RE] = LAP_SCALE_RST;
            coeff[CFG_LAP_SCALE_IM] = LAP_SCALE_RST;
            coeff[CFG_KINETIC]      = KINETIC_RST;
            coeff[CFG_TIME]         = TIME_RST;
        endfunction

        function void set_coeff(cfg_idx_t idx, word_t v);
            coeff[idx] = v;
        endfunction

        // q8.24 product, floor shift, wrapped to one word
        function word_t qmul(word_t a, word_t b);
            logic signed [63:0] p;
            p = $signed(a) * $signed(b);
            return p[55:24];
        endfunction

        function word_t five_point(ref word_t g[CELLS], input int i);
            return g[i+1] + g[i-1] + g[i+GRID_COLS] + g[i-GRID_COLS] - 4 * g[i];
        endfunction

        function void advance_grid();
            int i;
            word_t t_re;
            word_t t_im;
            for (int r = 1; r < GRID_ROWS - 1; r++)
                for (int c = 1; c < GRID_COLS - 1; c++)
                begin
                    i = r * GRID_COLS + c;
                    lap_re[i] = qmul(coeff[CFG_LAP_SCALE_RE], five_point(wave_re, i));
                    lap_im[i] = qmul(coeff[CFG_LAP_SCALE_IM], five_point(wave_im, i));
                end
            for (int r = 1; r < GRID_ROWS - 1; r++)
                for (int c = 1; c < GRID_COLS - 1; c++)
                begin
                    i = r * GRID_COLS + c;
                    t_re = qmul(pot[i], wave_re[i]) + qmul(coeff[CFG_KINETIC], lap_re[i]);
                    t_im = qmul(pot[i], wave_im[i]) + qmul(coeff[CFG_KINETIC], lap_im[i]);
                    wave_re[i] = wave_re[i] + qmul(coeff[CFG_TIME], t_im);
                    wave_im[i] = wave_im[i] - qmul(coeff[CFG_TIME], t_re);
                end
        endfunction

        function void note_request(in_item_t it);
            out_item_t res;
            int i;
            res = '0;
            i = int'(it.row) * GRID_COLS + int'(it.col);
            case (it.action)
                ACT_WRITE:
                begin
                    wave_re[i] = it.value_real;
                    wave_im[i] = it.value_imag;
                    pot[i]     = it.potential_in;
                    n_write++;
                end
                ACT_READ:
                begin
                    res.cell_real      = wave_re[i];
                    res.cell_imag      = wave_im[i];
                    res.cell_potential = pot[i];
                    n_read++;
                end
                ACT_STEP:
                begin
                    advance_grid();
                    res.step_done = 1'b1;
                    n_step++;
                end
                default: n_other++;
            endcase
            owed.push_back(res);
        endfunction

        function void check_result(out_item_t got);
            out_item_t exp_r;
            if (owed.size() == 0)
            begin
                $error("result %h arrived with none owed", got);
                errors++;
                return;
            end
            exp_r = owed.pop_front();
            if (got.cell_real !== exp_r.cell_real)
            begin
                $error("cell_real expected %h got %h", exp_r.cell_real, got.cell_real);
                errors++;
            end
            if (got.cell_imag !== exp_r.cell_imag)
            begin
                $error("cell_imag expected %h got %h", exp_r.cell_imag, got.cell_imag);
                errors++;
            end
            if (got.cell_potential !== exp_r.cell_potential)
            begin
                $error("cell_potential expected %h got %h",
                       exp_r.cell_potential, got.cell_potential);
                errors++;
            end
            if (got.step_done !== exp_r.step_done)
            begin
                $error("step_done expected %b got %b", exp_r.step_done, got.step_done);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_ready;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_ready;
    out_item_t  out_data;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [1:0] cfg_index;
    word_t      cfg_data;

    grid_scoreboard sb;
    int  cycles = 0;
    int  in_gap;
    bit  no_idle;   // stretches where neither side idles

    schrodinger_grid_step_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // watchdog on the whole run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[schrodinger_grid_step_core] ERROR");
            $finish;
        end
    end

    function automatic in_item_t make_req(action_t a, logic [5:0] r, logic [5:0] c,
                                          word_t re, word_t im, word_t v);
        in_item_t it;
        it.action       = a;
        it.row          = r;
        it.col          = c;
        it.value_real   = re;
        it.value_imag   = im;
        it.potential_in = v;
        return it;
    endfunction

    // full range half the time, otherwise a small q8.24 value around +-2.0
    function automatic word_t rand_word();
        if ($urandom_range(0, 1))
            return $urandom;
        return word_t'(int'($urandom_range(0, 32'h0400_0000)) - 32'sh0200_0000);
    endfunction

    // sender side: called and returns at a falling edge
    task automatic send_request(in_item_t it);
        if (in_gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (in_gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
        sb.note_request(it);
        @(negedge clk);
        in_gap = no_idle ? 0 : $urandom_range(0, 5);
    endtask

    task automatic write_coeff(cfg_idx_t idx, word_t v);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        sb.set_coeff(idx, v);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // drain every owed result so the core is idle for a register write
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (sb.owed.size() > 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_coeffs(word_t sre, word_t sim, word_t kin, word_t tc);
        wait_idle();
        write_coeff(CFG_LAP_SCALE_RE, sre);
        write_coeff(CFG_LAP_SCALE_IM, sim);
        write_coeff(CFG_KINETIC, kin);
        write_coeff(CFG_TIME, tc);
    endtask

    // mostly writes and reads over the filled grid, a rare step, some unused codes
    task automatic random_phase(int count);
        int pick;
        for (int n = 0; n < count; n++)
        begin
            if (n % 60 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            pick = $urandom_range(0, 999);
            if (pick < 470)
                send_request(make_req(ACT_WRITE, 6'($urandom), 6'($urandom),
                                      rand_word(), rand_word(), rand_word()));
            else if (pick < 950)
                send_request(make_req(ACT_READ, 6'($urandom), 6'($urandom),
                                      $urandom, $urandom, $urandom));
            else if (pick < 994)
                send_request(make_req(action_t'(2'd3), 6'($urandom), 6'($urandom),
                                      $urandom, $urandom, $urandom));
            else
                send_request(make_req(ACT_STEP, 6'($urandom), 6'($urandom),
                                      $urandom, $urandom, $urandom));
        end
    endtask

    // receiver side: random stall before each result
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 5);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do @(posedge clk); while (!out_valid);
            sb.check_result(out_data);
            @(negedge clk);
        end
    end

    initial
    begin
        sb        = new();
        in_gap    = 0;
        no_idle   = 1'b0;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_LAP_SCALE_RE;
        cfg_data  = '0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // directed: field extremes at the corners, unused action code
        send_request(make_req(ACT_WRITE, 6'd0, 6'd0, 32'h7FFF_FFFF, 32'h8000_0000,
                              32'hFFFF_FFFF));
        send_request(make_req(ACT_READ, 6'd0, 6'd0, '0, '0, '0));
        send_request(make_req(ACT_WRITE, 6'd63, 6'd63, 32'h8000_0000, 32'h7FFF_FFFF,
                              32'h0000_0000));
        send_request(make_req(ACT_READ, 6'd63, 6'd63, '1, '1, '1));
        send_request(make_req(ACT_WRITE, 6'd0, 6'd63, '0, '0, 32'h7FFF_FFFF));
        send_request(make_req(ACT_WRITE, 6'd63, 6'd0, '1, 32'h0100_0000, 32'h8000_0000));
        send_request(make_req(ACT_READ, 6'd63, 6'd0, '0, '0, '0));
        send_request(make_req(ACT_READ, 6'd0, 6'd63, '0, '0, '0));
        send_request(make_req(action_t'(2'd3), 6'd63, 6'd63, '1, '1, '1));
        send_request(make_req(action_t'(2'd3), 6'd0, 6'd0, '0, '0, '0));

        // every cell gets a value before any step or random read touches it
        no_idle = 1'b1;
        for (int r = 0; r < GRID_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                send_request(make_req(ACT_WRITE, 6'(r), 6'(c), rand_word(), rand_word(),
                                      rand_word()));
        no_idle = 1'b0;

        // one step under reset coefficients, then look at its neighborhood
        send_request(make_req(ACT_STEP, '0, '0, '0, '0, '0));
        send_request(make_req(ACT_READ, 6'd1, 6'd1, '0, '0, '0));
        send_request(make_req(ACT_READ, 6'd62, 6'd62, '0, '0, '0));
        send_request(make_req(ACT_READ, 6'd0, 6'd5, '0, '0, '0));
        send_request(make_req(ACT_READ, 6'd31, 6'd32, '0, '0, '0));

        random_phase(300);
        load_coeffs(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(make_req(ACT_STEP, '0, '0, '0, '0, '0));
        random_phase(250);
        load_coeffs(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(make_req(ACT_STEP, '0, '0, '0, '0, '0));
        random_phase(250);
        load_coeffs('0, '0, '0, '0);
        send_request(make_req(ACT_STEP, '0, '0, '0, '0, '0));
        random_phase(250);
        load_coeffs($urandom, $urandom, $urandom, $urandom);
        random_phase(350);
        load_coeffs(32'h0040_0000, 32'h00C0_0000, 32'hFF00_0000, 32'h0001_0000);
        random_phase(400);

        wait_idle();
        repeat (16) @(negedge clk);
        $display("covered %0d writes, %0d reads, %0d steps, %0d unused-code requests",
                 sb.n_write, sb.n_read, sb.n_step, sb.n_other);
        $display("six coefficient settings including all-max, all-min and zero");
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("[schrodinger_grid_step_core] OK");
        else
            $display("[schrodinger_grid_step_core] ERROR");
        $finish;
    end
endmodule
